FILE: hw/rtl/vkc_pkg.sv
package vkc_pkg;

   // queue between front and back
   localparam int VKC_QUEUE_DEPTH = 2;

   // maximum characters per key event
   localparam int VKC_MAX_CHARS = 3;

   // key codes
   localparam logic [7:0] KEY_BACK   = 8'h08;
   localparam logic [7:0] KEY_TAB    = 8'h09;
   localparam logic [7:0] KEY_RETURN = 8'h0D;
   localparam logic [7:0] KEY_ESCAPE = 8'h1B;
   localparam logic [7:0] KEY_SPACE  = 8'h20;

   // ascii codes
   localparam logic [6:0] ASCII_NUL = 7'h00;
   localparam logic [6:0] ASCII_BS  = 7'h08;
   localparam logic [6:0] ASCII_TAB = 7'h09;
   localparam logic [6:0] ASCII_LF  = 7'h0A;
   localparam logic [6:0] ASCII_CR  = 7'h0D;
   localparam logic [6:0] ASCII_ESC = 7'h1B;
   localparam logic [6:0] ASCII_SP  = 7'h20;
   localparam logic [6:0] CASE_GAP  = 7'd32;

   // shifted symbols on the digit row, indexed by digit
   localparam logic [9:0][6:0] SHIFTED_DIGITS = '{
      7'h28, 7'h2A, 7'h26, 7'h5E, 7'h25, 7'h24, 7'h23, 7'h40, 7'h21, 7'h29
   };

   typedef struct packed {
      logic [7:0] virtual_key;
      logic [7:0] scan_code;
      logic       shift_down;
      logic       caps_on;
      logic       menu_held;
      logic       prev_down;
      logic       key_up;
      logic [2:0] buffer_room;
   } req_item_type;

   typedef struct packed {
      logic [6:0] char_code;
      logic       char_valid;
      logic       last_char;
      logic       bad_room;
   } rsp_item_type;

   // classified key event: up to three characters, count 0 means no character
   typedef struct packed {
      logic [VKC_MAX_CHARS-1:0][6:0] chars;
      logic [1:0]                    count;
      logic                          bad;
   } job_type;

   // set-1 scan code punctuation fallback
   function automatic logic [6:0] punct(input logic [7:0] sc, input logic sh);
      logic [6:0] r;
      case (sc)
         8'h0C:   r = sh ? 7'h5F : 7'h2D;
         8'h0D:   r = sh ? 7'h2B : 7'h3D;
         8'h1A:   r = sh ? 7'h7B : 7'h5B;
         8'h1B:   r = sh ? 7'h7D : 7'h5D;
         8'h27:   r = sh ? 7'h3A : 7'h3B;
         8'h28:   r = sh ? 7'h22 : 7'h27;
         8'h29:   r = sh ? 7'h7E : 7'h60;
         8'h2B:   r = sh ? 7'h7C : 7'h5C;
         8'h33:   r = sh ? 7'h3C : 7'h2C;
         8'h34:   r = sh ? 7'h3E : 7'h2E;
         8'h35:   r = sh ? 7'h3F : 7'h2F;
         default: r = ASCII_NUL;
      endcase
      return r;
   endfunction

   // main character of a key press, nul when unmapped
   function automatic logic [6:0] translate(input logic [7:0] vk, input logic [7:0] sc,
                                            input logic sh, input logic caps);
      logic [6:0] r;
      logic [3:0] digit;
      digit = vk[3:0];
      case (vk) inside
         [8'h41:8'h5A]: r = (caps != sh) ? vk[6:0] : vk[6:0] + CASE_GAP;
         [8'h30:8'h39]: r = sh ? SHIFTED_DIGITS[digit] : vk[6:0];
         KEY_SPACE:     r = ASCII_SP;
         KEY_RETURN:    r = ASCII_CR;
         KEY_TAB:       r = ASCII_TAB;
         KEY_BACK:      r = ASCII_BS;
         KEY_ESCAPE:    r = ASCII_ESC;
         default:       r = punct(sc, sh);
      endcase
      return r;
   endfunction

endpackage

FILE: hw/rtl/virtual_key_to_char_translator_top.sv
// Turns one key event into up to three US-layout ASCII characters (ESC prefix
// in menu mode, the key's character, LF after return), each leaving as its own
// result with last_char on the final one; release, autorepeat, unmapped keys and
// no room give one result with char_valid low, and zero room gives bad_room.
// A new event is taken every cycle while the queue of classified events has
// space; results leave one per cycle while pop is given, so an event gives one
// to three results, set by the number of characters the emitter walks through.
// The first result of an event passes through a queue slot and then the output
// register before it shows on the result ports.
module virtual_key_to_char_translator_top #(
   parameter int QueueDepth = vkc_pkg::VKC_QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  vkc_pkg::req_item_type req_item,
   output logic                  empty,
   input  logic                  pop,
   output vkc_pkg::rsp_item_type rsp_item
);
   import vkc_pkg::*;

   job_type new_job;
   job_type head_job;
   logic    head_empty;
   logic    head_done;

   // classify the incoming key event
   vkc_front u_front (
      .item (req_item),
      .job  (new_job)
   );

   // decoupling queue
   vkc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (new_job),
      .full    (full),
      .rd_en   (head_done),
      .rd_data (head_job),
      .empty   (head_empty)
   );

   // emit characters one per cycle while the result side is popped
   vkc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (head_job),
      .job_empty (head_empty),
      .job_done  (head_done),
      .rsp_item  (rsp_item),
      .empty     (empty),
      .pop       (pop)
   );

endmodule

FILE: hw/rtl/vkc_front.sv
module vkc_front (
   input  vkc_pkg::req_item_type item,
   output vkc_pkg::job_type      job
);
   import vkc_pkg::*;

   logic [6:0] ch;
   logic [1:0] cap;
   logic [1:0] n;
   logic [VKC_MAX_CHARS-1:0][6:0] buf_chars;

   // room left beyond the terminator
   always_comb begin
      if (item.buffer_room >= 3'd4) begin
         cap = 2'd3;
      end else begin
         cap = item.buffer_room[1:0] - 2'd1;
      end
   end

   assign ch = translate(item.virtual_key, item.scan_code, item.shift_down, item.caps_on);

   // pack prefix, main character and line feed while room lasts
   always_comb begin
      n         = 2'd0;
      buf_chars = '0;
      if (item.menu_held && ch != ASCII_NUL && ch != ASCII_ESC && n < cap) begin
         buf_chars[n] = ASCII_ESC;
         n            = n + 2'd1;
      end
      if (ch != ASCII_NUL && n < cap) begin
         buf_chars[n] = ch;
         n            = n + 2'd1;
      end
      if (item.virtual_key == KEY_RETURN && n < cap) begin
         buf_chars[n] = ASCII_LF;
         n            = n + 2'd1;
      end
   end

   // zero room and release or autorepeat give no character
   always_comb begin
      job.chars = buf_chars;
      job.bad   = (item.buffer_room == 3'd0);
      if (job.bad || item.key_up || item.prev_down) begin
         job.count = 2'd0;
      end else begin
         job.count = n;
      end
   end

endmodule

FILE: hw/rtl/vkc_queue.sv
module vkc_queue #(
   parameter int Depth = vkc_pkg::VKC_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  vkc_pkg::job_type wr_data,
   output logic             full,
   input  logic             rd_en,
   output vkc_pkg::job_type rd_data,
   output logic             empty
);
   import vkc_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   job_type             slot_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_wr, do_rd;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: hw/rtl/vkc_back.sv
module vkc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  vkc_pkg::job_type      job,
   input  logic                  job_empty,
   output logic                  job_done,
   output vkc_pkg::rsp_item_type rsp_item,
   output logic                  empty,
   input  logic                  pop
);
   import vkc_pkg::*;

   logic [1:0]   idx_ff, idx_in;
   rsp_item_type rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         advance;
   logic         load;
   logic         is_last;

   assign empty    = !rsp_valid_ff;
   assign rsp_item = rsp_ff;
   assign advance  = !rsp_valid_ff || pop;
   assign load     = advance && !job_empty;
   assign is_last  = (job.count == 2'd0) || (idx_ff + 2'd1 == job.count);
   assign job_done = load && is_last;

   // next character of the head transaction
   always_comb begin
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = load;
      end
      if (load) begin
         if (job.count == 2'd0) begin
            rsp_in.char_code  = ASCII_NUL;
            rsp_in.char_valid = 1'b0;
            rsp_in.bad_room   = job.bad;
         end else begin
            rsp_in.char_code  = job.chars[idx_ff];
            rsp_in.char_valid = 1'b1;
            rsp_in.bad_room   = 1'b0;
         end
         rsp_in.last_char = is_last;
         idx_in           = is_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

endmodule

FILE: hw/rtl/vkc_checker.sv
module vkc_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  empty,
   input logic                  pop,
   input vkc_pkg::rsp_item_type rsp_item
);
   import vkc_pkg::*;

   // nothing waits on the result side straight after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result shown right after reset");

   // zero room is reported as a lone, empty final result
   a_bad_room_shape: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.bad_room) |-> (!rsp_item.char_valid && rsp_item.last_char))
      else $error("bad room result carries a character");

   // an empty result is always the only one of its transaction, with nul code
   a_no_char_shape: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_item.char_valid) |->
         (rsp_item.last_char && rsp_item.char_code == ASCII_NUL))
      else $error("empty result not final or code not nul");

   // a result that does not end its transaction is followed by another
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_item.last_char) |=> (!empty && rsp_item.char_valid))
      else $error("character run broken off");

   // stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_item)))
      else $error("stalled result changed");

endmodule

bind virtual_key_to_char_translator_top vkc_checker u_vkc_checker (
   .clock    (clock),
   .reset    (reset),
   .empty    (empty),
   .pop      (pop),
   .rsp_item (rsp_item)
);
